>>> hw/rtl/rvalu_pkg.sv
// ----------------------------------------------------------------------------
// rvalu_pkg: shared types and constants of the RV64IM integer execute unit
// Request and response payloads, operation codes and the decoded micro-op.
// ----------------------------------------------------------------------------
package rvalu_pkg;

  // Raw operation codes as they arrive in the kind field
  localparam logic [8:0] K_ADD    = 9'h000;
  localparam logic [8:0] K_SUB    = 9'h100;
  localparam logic [8:0] K_SLL    = 9'h001;
  localparam logic [8:0] K_SLT    = 9'h002;
  localparam logic [8:0] K_SLTU   = 9'h003;
  localparam logic [8:0] K_XOR    = 9'h004;
  localparam logic [8:0] K_SRL    = 9'h005;
  localparam logic [8:0] K_SRA    = 9'h105;
  localparam logic [8:0] K_OR     = 9'h006;
  localparam logic [8:0] K_AND    = 9'h007;
  localparam logic [8:0] K_MUL    = 9'h008;
  localparam logic [8:0] K_MULH   = 9'h009;
  localparam logic [8:0] K_MULHSU = 9'h00a;
  localparam logic [8:0] K_MULHU  = 9'h00b;
  localparam logic [8:0] K_DIV    = 9'h00c;
  localparam logic [8:0] K_DIVU   = 9'h00d;
  localparam logic [8:0] K_REM    = 9'h00e;
  localparam logic [8:0] K_REMU   = 9'h00f;

  localparam int XLEN      = 64;
  localparam int DIV_STEPS = XLEN;   // one quotient bit per stage
  localparam int MUL_TAP   = 3;      // stage that picks up the product

  typedef struct packed {
    logic [8:0]  kind;
    logic        word_mode;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } alu_req_t;

  typedef struct packed {
    logic [63:0] value;
    logic        invalid_op;
  } alu_rsp_t;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_SLL, OP_SLT, OP_SLTU, OP_XOR, OP_SRL, OP_SRA, OP_OR,
    OP_AND, OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU, OP_DIV, OP_DIVU, OP_REM,
    OP_REMU
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        word;
    logic        bad;
    logic [63:0] a;
    logic [63:0] b;
  } uop_t;

  function automatic logic [63:0] sext32(input logic [63:0] x);
    return {{32{x[31]}}, x[31:0]};
  endfunction

endpackage

>>> hw/rtl/rvalu_front.sv
// ----------------------------------------------------------------------------
// rvalu_front: request decode and micro-op queue
// Classifies each request; flags unknown codes, unsupported word-mode ops and
// zero divisors; holds decoded micro-ops until the execute pipeline takes them.
// ----------------------------------------------------------------------------
module rvalu_front #(
  parameter int Depth = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rvalu_pkg::alu_req_t req,
  output logic                uop_valid,
  output rvalu_pkg::uop_t     uop,
  input  logic                uop_take
);
  import rvalu_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  uop_t            q_mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  op_t  op;
  logic known;
  logic word_ok;
  logic is_div;
  logic b_zero;
  uop_t dec;
  logic push;
  logic pop;

  always_comb begin
    op    = OP_ADD;
    known = 1'b1;
    case (req.kind)
      K_ADD:    op = OP_ADD;
      K_SUB:    op = OP_SUB;
      K_SLL:    op = OP_SLL;
      K_SLT:    op = OP_SLT;
      K_SLTU:   op = OP_SLTU;
      K_XOR:    op = OP_XOR;
      K_SRL:    op = OP_SRL;
      K_SRA:    op = OP_SRA;
      K_OR:     op = OP_OR;
      K_AND:    op = OP_AND;
      K_MUL:    op = OP_MUL;
      K_MULH:   op = OP_MULH;
      K_MULHSU: op = OP_MULHSU;
      K_MULHU:  op = OP_MULHU;
      K_DIV:    op = OP_DIV;
      K_DIVU:   op = OP_DIVU;
      K_REM:    op = OP_REM;
      K_REMU:   op = OP_REMU;
      default:  known = 1'b0;
    endcase
    word_ok = op inside {OP_ADD, OP_SUB, OP_SLL, OP_SRL, OP_SRA, OP_MUL,
                         OP_DIV, OP_DIVU, OP_REM, OP_REMU};
    is_div  = op inside {OP_DIV, OP_DIVU, OP_REM, OP_REMU};
    b_zero  = req.word_mode ? (req.operand_b[31:0] == 32'd0)
                            : (req.operand_b == 64'd0);
    dec.op   = op;
    dec.word = req.word_mode;
    dec.bad  = !known || (req.word_mode && !word_ok) || (is_div && b_zero);
    dec.a    = req.operand_a;
    dec.b    = req.operand_b;
  end

  assign req_stall = (count == CntW'(Depth));
  assign uop_valid = (count != '0);
  assign uop       = q_mem[rd_ptr];
  assign push      = req_valid && !req_stall;
  assign pop       = uop_take && uop_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("micro-op queue overfilled");
`endif

endmodule

>>> hw/rtl/rvalu_back.sv
// ----------------------------------------------------------------------------
// rvalu_back: execute pipeline
// ALU and operand prep, split 64x64 multiplier, one-bit-per-stage divider,
// sign fix and word-mode extension, response register.
// ----------------------------------------------------------------------------
module rvalu_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                uop_valid,
  input  rvalu_pkg::uop_t     uop,
  output logic                uop_take,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rvalu_pkg::alu_rsp_t rsp
);
  import rvalu_pkg::*;

  typedef struct packed {
    op_t         op;
    logic        word;
    logic        bad;
    logic        neg;
    logic [63:0] res;
    logic [63:0] r;
    logic [63:0] q;
    logic [63:0] mb;
  } stg_t;

  logic advance;
  assign advance  = !(rsp_valid && rsp_stall);
  assign uop_take = advance;

  // ---------------- prep stage ----------------
  logic [5:0]  sh;
  logic [63:0] alu;
  logic        sgn;
  logic [63:0] da;
  logic [63:0] db;
  logic        na;
  logic        nb;
  logic [63:0] corr_in;
  stg_t        prep;

  always_comb begin
    sh = uop.word ? {1'b0, uop.b[4:0]} : uop.b[5:0];
    case (uop.op)
      OP_ADD:  alu = uop.a + uop.b;
      OP_SUB:  alu = uop.a - uop.b;
      OP_SLL:  alu = uop.a << sh;
      OP_SLT:  alu = {63'd0, $signed(uop.a) < $signed(uop.b)};
      OP_SLTU: alu = {63'd0, uop.a < uop.b};
      OP_XOR:  alu = uop.a ^ uop.b;
      OP_SRL:  alu = (uop.word ? {32'd0, uop.a[31:0]} : uop.a) >> sh;
      OP_SRA:  alu = $unsigned($signed(uop.word ? sext32(uop.a) : uop.a) >>> sh);
      OP_OR:   alu = uop.a | uop.b;
      OP_AND:  alu = uop.a & uop.b;
      default: alu = 64'd0;
    endcase

    sgn = (uop.op == OP_DIV) || (uop.op == OP_REM);
    if (uop.word) begin
      da = sgn ? sext32(uop.a) : {32'd0, uop.a[31:0]};
      db = sgn ? sext32(uop.b) : {32'd0, uop.b[31:0]};
    end else begin
      da = uop.a;
      db = uop.b;
    end
    na = sgn && da[63];
    nb = sgn && db[63];

    corr_in = 64'd0;
    if (uop.op == OP_MULH) begin
      corr_in = (uop.a[63] ? uop.b : 64'd0) + (uop.b[63] ? uop.a : 64'd0);
    end else if (uop.op == OP_MULHSU) begin
      corr_in = uop.a[63] ? uop.b : 64'd0;
    end

    prep.op   = uop.op;
    prep.word = uop.word;
    prep.bad  = uop.bad;
    prep.neg  = (uop.op == OP_REM) ? na : (na ^ nb);
    prep.res  = alu;
    prep.r    = 64'd0;
    prep.q    = na ? (64'd0 - da) : da;
    prep.mb   = nb ? (64'd0 - db) : db;
  end

  stg_t st [DIV_STEPS+1];
  logic st_valid [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0] <= prep;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid[0] <= 1'b0;
    end else if (advance) begin
      st_valid[0] <= uop_valid;
    end
  end

  // ---------------- multiplier ----------------
  logic [63:0] m1_ll, m1_lh, m1_hl, m1_hh, m1_corr;
  logic [33:0] m2_mid;
  logic [31:0] m2_lo;
  logic [63:0] m2_hpart, m2_corr;
  logic [63:0] m3_hi, m3_lo;

  always_ff @(posedge clk) begin
    if (advance) begin
      m1_ll    <= uop.a[31:0]  * uop.b[31:0];
      m1_lh    <= uop.a[31:0]  * uop.b[63:32];
      m1_hl    <= uop.a[63:32] * uop.b[31:0];
      m1_hh    <= uop.a[63:32] * uop.b[63:32];
      m1_corr  <= corr_in;
      m2_mid   <= {2'b0, m1_ll[63:32]} + {2'b0, m1_lh[31:0]} + {2'b0, m1_hl[31:0]};
      m2_lo    <= m1_ll[31:0];
      m2_hpart <= m1_hh + {32'd0, m1_lh[63:32]} + {32'd0, m1_hl[63:32]};
      m2_corr  <= m1_corr;
      m3_hi    <= m2_hpart + {62'd0, m2_mid[33:32]} - m2_corr;
      m3_lo    <= {m2_mid[31:0], m2_lo};
    end
  end

  // ---------------- divider stages ----------------
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [64:0] t;
    logic [64:0] diff;
    logic        ge;
    stg_t        nx;

    always_comb begin
      nx   = st[k-1];
      t    = {st[k-1].r, st[k-1].q[63]};
      diff = t - {1'b0, st[k-1].mb};
      ge   = !diff[64];
      nx.r = ge ? diff[63:0] : t[63:0];
      nx.q = {st[k-1].q[62:0], ge};
      if (k == MUL_TAP) begin
        case (st[k-1].op)
          OP_MUL:                        nx.res = m3_lo;
          OP_MULH, OP_MULHSU, OP_MULHU:  nx.res = m3_hi;
          default:                       nx.res = st[k-1].res;
        endcase
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        st[k] <= nx;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (advance) begin
        st_valid[k] <= st_valid[k-1];
      end
    end
  end

  // ---------------- finish and response ----------------
  stg_t        fin;
  logic [63:0] dres;
  logic [63:0] val;

  always_comb begin
    fin  = st[DIV_STEPS];
    dres = ((fin.op == OP_DIV) || (fin.op == OP_DIVU)) ? fin.q : fin.r;
    if (((fin.op == OP_DIV) || (fin.op == OP_REM)) && fin.neg) begin
      dres = 64'd0 - dres;
    end
    val = (fin.op inside {OP_DIV, OP_DIVU, OP_REM, OP_REMU}) ? dres : fin.res;
    if (fin.word) begin
      val = sext32(val);
    end
    if (fin.bad) begin
      val = 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.value      <= val;
      rsp.invalid_op <= fin.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= st_valid[DIV_STEPS];
    end
  end

`ifndef SYNTHESIS
  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st_valid[DIV_STEPS]) &&
                 (!st_valid[DIV_STEPS] || $stable(st[DIV_STEPS])))
    else $error("pipeline moved while response held");
`endif

endmodule

>>> hw/rtl/rv64_integer_alu_muldiv_unit.sv
// ----------------------------------------------------------------------------
// rv64_integer_alu_muldiv_unit: RV64IM integer execute unit
// ALU, multiplier and divider behind a decoded micro-op queue.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  req     | in  | req_valid/req_stall  | alu_req_t: kind, word_mode, operands
//  rsp     | out | rsp_valid/rsp_stall  | alu_rsp_t: value, invalid_op
//
//  One request per cycle sustained while no response is held; every op runs the same fixed-length path.
//  Path: queue, prep register, 64 divider stages (one quotient bit each), then
//  the response register. The multiply finishes early and rides along.
//  rst is synchronous; it empties the queue and clears all stage valid bits.
//  rsp_stall on a valid response freezes the whole execute pipeline; the queue
//  keeps absorbing requests until full, then raises req_stall.
// ----------------------------------------------------------------------------
module rv64_integer_alu_muldiv_unit #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  rvalu_pkg::alu_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output rvalu_pkg::alu_rsp_t rsp
);
  import rvalu_pkg::*;

  logic uop_valid;
  logic uop_take;
  uop_t uop;

  // Decode and queue: transfer requests in, hold micro-ops for the back end
  rvalu_front #(
    .Depth(QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .uop_valid (uop_valid),
    .uop       (uop),
    .uop_take  (uop_take)
  );

  // Execute: advance every stage together unless the response is held
  rvalu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .uop_valid (uop_valid),
    .uop       (uop),
    .uop_take  (uop_take),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.invalid_op |-> rsp.value == 64'd0)
    else $error("invalid response carries nonzero value");

  a_take_when_free: assert property (@(posedge clk) disable iff (rst)
    !(rsp_valid && rsp_stall) |-> uop_take)
    else $error("back end refused micro-op while free");
`endif

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the RV64IM integer execute unit
// A table of directed requests, then constrained-free random requests, run
// through three idling regimes and a long response hold-off. Each response is
// compared against an independent behavioral predictor, in order.
// ----------------------------------------------------------------------------
module tb;
  import rvalu_pkg::*;

  localparam int LATENCY   = 67;
  localparam int WATCHDOG  = 20000;
  localparam int N_RANDOM  = 680;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  alu_req_t req;
  logic     rsp_valid;
  logic     rsp_stall;
  alu_rsp_t rsp;

  rv64_integer_alu_muldiv_unit DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  // Directed row: known result typed in only where obvious
  typedef struct {
    logic [8:0]  kind;
    logic        word_mode;
    logic [63:0] a;
    logic [63:0] b;
    logic        known;
    logic [63:0] value;
    logic        bad;
  } row_t;

  alu_rsp_t  expected_rsps[$];
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_idle_pct;
  bit        hold_off;
  bit        timed_out;
  int        quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // 128-bit product helper; sa and sb sign-extend the operands for the signed forms
  function automatic logic [127:0] widen_mul(logic [63:0] a, logic [63:0] b, bit sa, bit sb);
    logic [127:0] xa, xb;
    xa = sa ? {{64{a[63]}}, a} : {64'd0, a};
    xb = sb ? {{64{b[63]}}, b} : {64'd0, b};
    return xa * xb;
  endfunction

  function automatic alu_rsp_t alu_predict(alu_req_t r);
    alu_rsp_t    o;
    logic [63:0] a, b, q;
    logic signed [63:0] sa, sb;
    logic [31:0] a32, b32;
    logic signed [31:0] s32a, s32b;
    bit          is_div;
    o = '0;
    a = r.operand_a;
    b = r.operand_b;
    a32 = a[31:0];
    b32 = b[31:0];
    sa = a;
    sb = b;
    s32a = a32;
    s32b = b32;
    is_div = r.kind inside {K_DIV, K_DIVU, K_REM, K_REMU};
    if (!r.word_mode) begin
      if (is_div && b == 0) begin
        o.invalid_op = 1'b1;
        return o;
      end
      case (r.kind)
        K_ADD:    q = a + b;
        K_SUB:    q = a - b;
        K_SLL:    q = a << b[5:0];
        K_SLT:    q = {63'd0, sa < sb};
        K_SLTU:   q = {63'd0, a < b};
        K_XOR:    q = a ^ b;
        K_SRL:    q = a >> b[5:0];
        K_SRA:    q = sa >>> b[5:0];
        K_OR:     q = a | b;
        K_AND:    q = a & b;
        K_MUL:    q = a * b;
        K_MULH:   q = widen_mul(a, b, 1'b1, 1'b1) >> 64;
        K_MULHSU: q = widen_mul(a, b, 1'b1, 1'b0) >> 64;
        K_MULHU:  q = widen_mul(a, b, 1'b0, 1'b0) >> 64;
        K_DIV:    q = (a == 64'h8000_0000_0000_0000 && sb == -1) ? a : $unsigned(sa / sb);
        K_DIVU:   q = a / b;
        K_REM:    q = (a == 64'h8000_0000_0000_0000 && sb == -1) ? 64'd0
                                                                 : $unsigned(sa % sb);
        K_REMU:   q = a % b;
        default:  begin o.invalid_op = 1'b1; return o; end
      endcase
    end else begin
      if (is_div && b32 == 0) begin
        o.invalid_op = 1'b1;
        return o;
      end
      case (r.kind)
        K_ADD:   q[31:0] = a32 + b32;
        K_SUB:   q[31:0] = a32 - b32;
        K_SLL:   q[31:0] = a32 << b[4:0];
        K_SRL:   q[31:0] = a32 >> b[4:0];
        K_SRA:   q[31:0] = s32a >>> b[4:0];
        K_MUL:   q[31:0] = a32 * b32;
        K_DIV:   q[31:0] = (a32 == 32'h8000_0000 && s32b == -1) ? a32
                                                                : $unsigned(s32a / s32b);
        K_DIVU:  q[31:0] = a32 / b32;
        K_REM:   q[31:0] = (a32 == 32'h8000_0000 && s32b == -1) ? 32'd0
                                                                : $unsigned(s32a % s32b);
        K_REMU:  q[31:0] = a32 % b32;
        default: begin o.invalid_op = 1'b1; return o; end
      endcase
      q = {{32{q[31]}}, q[31:0]};
    end
    o.value = q;
    return o;
  endfunction

  function automatic logic [63:0] rand64();
    logic [63:0] v;
    case ($urandom_range(0, 7))
      0: v = 64'd0;
      1: v = 64'hFFFF_FFFF_FFFF_FFFF;
      2: v = 64'h8000_0000_0000_0000;
      3: v = {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0, 32'h8000_0000};
      4: v = 64'($urandom_range(0, 80));
      5: v = {32'd0, $urandom};
      default: v = {$urandom, $urandom};
    endcase
    return v;
  endfunction

  function automatic logic [8:0] rand_kind();
    logic [8:0] valid_codes[18] = '{K_ADD, K_SUB, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL,
      K_SRA, K_OR, K_AND, K_MUL, K_MULH, K_MULHSU, K_MULHU, K_DIV, K_DIVU, K_REM, K_REMU};
    if ($urandom_range(0, 9) == 0) return 9'($urandom);
    return valid_codes[$urandom_range(0, 17)];
  endfunction

  // Offer one request and hold it until the transfer happens
  task automatic send_req(alu_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsps.push_back(alu_predict(r));
  endtask

  task automatic drain();
    while (expected_rsps.size() != 0 && !timed_out) @(posedge clk);
  endtask

  // Receiver: random stalls, plus an explicit long hold-off
  initial begin : recv_side
    int held;
    rsp_stall = 1'b1;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        rsp_stall <= 1'b1;
        for (held = 0; held < 300; held++) @(posedge clk);
        hold_off = 1'b0;
      end
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Compare each response transfer with the oldest prediction
  always @(posedge clk) begin
    alu_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected response %h", rsp);
      end else begin
        want = expected_rsps.pop_front();
        if (rsp.value !== want.value || rsp.invalid_op !== want.invalid_op) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: value exp %h got %h, invalid exp %b got %b",
                     want.value, rsp.value, want.invalid_op, rsp.invalid_op);
        end
      end
    end
  end

  // Watchdog: restart on any transfer, give up after a long quiet stretch
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1'b1;
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    row_t     rows[$];
    alu_req_t r;
    alu_rsp_t typed;
    int       phase, i;
    logic [63:0] mn;
    mn = 64'h8000_0000_0000_0000;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    mismatch_count = 0;
    quiet_cycles = 0;
    hold_off = 1'b0;
    timed_out = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Directed table: extremes, every operation and the special cases
    rows = '{
      '{K_ADD,  0, '1, 64'd1, 1, 64'd0, 0},
      '{K_SUB,  0, 64'd0, 64'd1, 1, '1, 0},
      '{K_SLL,  0, 64'd1, 64'd63, 1, mn, 0},
      '{K_SLT,  0, mn, 64'd0, 1, 64'd1, 0},
      '{K_SLTU, 0, mn, 64'd0, 1, 64'd0, 0},
      '{K_XOR,  0, '1, 64'h5555_5555_5555_5555, 0, 0, 0},
      '{K_SRL,  0, mn, 64'd63, 1, 64'd1, 0},
      '{K_SRA,  0, mn, 64'd63, 1, '1, 0},
      '{K_OR,   0, 64'hF0F0, 64'h0F0F, 0, 0, 0},
      '{K_AND,  0, '1, 64'h1234_5678_9ABC_DEF0, 0, 0, 0},
      '{K_MUL,  0, '1, '1, 1, 64'd1, 0},
      '{K_MULH, 0, mn, mn, 0, 0, 0},
      '{K_MULHSU, 0, '1, '1, 0, 0, 0},
      '{K_MULHU, 0, '1, '1, 0, 0, 0},
      '{K_DIV,  0, mn, '1, 1, mn, 0},
      '{K_REM,  0, mn, '1, 1, 64'd0, 0},
      '{K_DIVU, 0, 64'd5, 64'd0, 1, 64'd0, 1},
      '{K_REMU, 0, '1, 64'h1_0000_0000, 0, 0, 0},
      '{K_DIV,  1, 64'h8000_0000, 64'hFFFF_FFFF, 1, 64'hFFFF_FFFF_8000_0000, 0},
      '{K_REM,  1, 64'h8000_0000, 64'hFFFF_FFFF, 1, 64'd0, 0},
      '{K_DIVU, 1, 64'd7, 64'hF_0000_0000, 1, 64'd0, 1},
      '{K_DIVU, 1, 64'hFFFF_FFFF, 64'd1, 1, '1, 0},
      '{K_SRA,  1, 64'h8000_0000, 64'd31, 1, '1, 0},
      '{K_SLT,  1, 64'd1, 64'd2, 1, 64'd0, 1},
      '{9'h1FF, 0, '1, '1, 1, 64'd0, 1}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[k]) begin
      r.kind = rows[k].kind;
      r.word_mode = rows[k].word_mode;
      r.operand_a = rows[k].a;
      r.operand_b = rows[k].b;
      typed.value = rows[k].value;
      typed.invalid_op = rows[k].bad;
      if (rows[k].known && alu_predict(r) !== typed) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("table row %0d: exp %h got %h", k, typed, alu_predict(r));
      end
      send_req(r);
    end
    // Long response hold-off while requests keep coming: fills the queue
    hold_off = 1'b1;
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 25 : 0;
      for (i = 0; i < N_RANDOM / 3; i++) begin
        r.kind = rand_kind();
        r.word_mode = $urandom_range(0, 1);
        r.operand_a = rand64();
        r.operand_b = rand64();
        send_req(r);
      end
    end
    req_valid <= 1'b0;
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatch_count == 0 && expected_rsps.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule

>>> rv64_integer_alu_muldiv_unit.f
hw/rtl/rvalu_pkg.sv
hw/rtl/rvalu_front.sv
hw/rtl/rvalu_back.sv
hw/rtl/rv64_integer_alu_muldiv_unit.sv
dv/tb.sv
